// ----- hdl/rs_enc_pkg.sv -----
// Package for the GF(2^8) Reed-Solomon systematic encoder.
// Holds field constants, queue entry type and the field multiply function.
// No dependencies.
package rs_enc_pkg;

   localparam int MaxParity = 16;
   localparam int SymW = 8;
   localparam int CntW = 5;
   localparam int QDepth = 2;

   localparam logic [1:0] RegFieldPoly = 2'd0;
   localparam logic [1:0] RegParityCnt = 2'd1;
   localparam logic [1:0] RegGenLow    = 2'd2;
   localparam logic [1:0] RegGenHigh   = 2'd3;

   typedef struct packed {
      logic [SymW-1:0] symbol;
      logic            last;
   } item_type;

   function automatic logic [SymW-1:0] gf_mul(input logic [SymW-1:0] a,
                                              input logic [SymW-1:0] b,
                                              input logic [SymW-1:0] poly);
      logic [SymW-1:0] acc;
      logic [SymW-1:0] x;
      acc = '0;
      x = a;
      for (int i = 0; i < SymW; i++) begin
         if (b[i]) acc = acc ^ x;
         x = x[SymW-1] ? ({x[SymW-2:0], 1'b0} ^ poly) : {x[SymW-2:0], 1'b0};
      end
      return acc;
   endfunction

endpackage

// ----- hdl/reed_solomon_systematic_encoder_top.sv -----
// Top level of the systematic Reed-Solomon encoder over GF(2^8).
// Depends on rs_enc_pkg, rs_enc_csr, rs_enc_front, rs_enc_back.
//
// Usage: message bytes enter on the req_ channel, highest degree first, with
// req_last_symbol on the final byte. Each byte appears on the rsp_ channel as
// a message transaction; after the last byte the t parity bytes follow,
// highest degree first; the codeword's final byte is flagged by rsp_end_of_codeword.
// An accepted byte passes through the queue and then the output register.
// Throughput: one message byte per cycle unless rsp_stall holds the output or
// parity drains; after a last byte, t parity bytes leave one per unstalled cycle.
// A two-entry queue separates intake from the LFSR, so req_stall rises only
// when the queue is full while the output is stalled or draining parity.
// Reset clears the queue, remainder and output valid and loads the register
// defaults. While rsp_stall is high the output transaction holds.
// Write registers (byte address 8*i) only while the block is idle.
module reed_solomon_systematic_encoder_top
   import rs_enc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [SymW-1:0] req_msg_symbol,
   input  logic            req_last_symbol,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [SymW-1:0] rsp_out_symbol,
   output logic            rsp_is_parity,
   output logic            rsp_end_of_codeword,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [4:0]      csr_paddr,
   input  logic [63:0]     csr_pwdata,
   output logic [63:0]     csr_prdata,
   output logic            csr_pready
);

   logic [SymW-1:0]           poly;
   logic [CntW-1:0]           parity_count;
   logic [MaxParity*SymW-1:0] gen;
   logic                      q_valid, q_pop;
   item_type                  q_item;

   rs_enc_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .poly, .parity_count, .gen
   );

   rs_enc_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_msg_symbol,
      .req_last_symbol, .q_valid, .q_pop, .q_item
   );

   rs_enc_back u_back (
      .clock, .reset, .q_valid, .q_pop, .q_item, .poly, .parity_count, .gen,
      .rsp_valid, .rsp_stall, .rsp_out_symbol, .rsp_is_parity,
      .rsp_end_of_codeword
   );

endmodule

// ----- hdl/rs_enc_front.sv -----
// Front end: accepts message bytes into a short queue.
// Depends on rs_enc_pkg.
module rs_enc_front
   import rs_enc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [SymW-1:0] req_msg_symbol,
   input  logic           req_last_symbol,
   output logic           q_valid,
   input  logic           q_pop,
   output item_type       q_item
);

   item_type  mem_ff [QDepth];
   item_type  mem_in;
   logic      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push;

   assign req_stall = (cnt_ff == 2'(QDepth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = mem_ff[rd_ptr_ff];
   assign mem_in    = '{symbol: req_msg_symbol, last: req_last_symbol};

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= mem_in;
   end

endmodule

// ----- hdl/rs_enc_back.sv -----
// Back end: division LFSR, parity drain and output register.
// Depends on rs_enc_pkg.
module rs_enc_back
   import rs_enc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  item_type             q_item,
   input  logic [SymW-1:0]      poly,
   input  logic [CntW-1:0]      parity_count,
   input  logic [MaxParity*SymW-1:0] gen,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SymW-1:0]      rsp_out_symbol,
   output logic                 rsp_is_parity,
   output logic                 rsp_end_of_codeword
);

   logic [SymW-1:0] rem_ff [MaxParity];
   logic [SymW-1:0] rem_in [MaxParity];
   logic [CntW-1:0] drain_ff, drain_in;
   logic            valid_ff, valid_in;
   logic [SymW-1:0] sym_ff, sym_in;
   logic            par_ff, par_in, eoc_ff, eoc_in;
   logic [CntW-1:0] t;
   logic [SymW-1:0] fb;
   logic            out_free;

   assign t = (parity_count > CntW'(MaxParity)) ? CntW'(MaxParity) : parity_count;
   assign out_free = !valid_ff || !rsp_stall;
   assign q_pop = out_free && (drain_ff == '0) && q_valid;
   assign fb = (t == '0) ? '0 : (q_item.symbol ^ rem_ff[4'(t - 1'b1)]);

   assign rsp_valid           = valid_ff;
   assign rsp_out_symbol      = sym_ff;
   assign rsp_is_parity       = par_ff;
   assign rsp_end_of_codeword = eoc_ff;

   always_comb begin
      rem_in   = rem_ff;
      drain_in = drain_ff;
      valid_in = valid_ff && rsp_stall;
      sym_in   = sym_ff;
      par_in   = par_ff;
      eoc_in   = eoc_ff;
      if (out_free && drain_ff != '0) begin
         valid_in = 1'b1;
         sym_in   = rem_ff[4'(drain_ff - 1'b1)];
         par_in   = 1'b1;
         eoc_in   = (drain_ff == CntW'(1));
         drain_in = drain_ff - 1'b1;
         if (drain_ff == CntW'(1)) begin
            for (int i = 0; i < MaxParity; i++) rem_in[i] = '0;
         end
      end else if (q_pop) begin
         valid_in = 1'b1;
         sym_in   = q_item.symbol;
         par_in   = 1'b0;
         eoc_in   = q_item.last && (t == '0);
         if (t != '0) begin
            for (int i = 0; i < MaxParity; i++) begin
               if (i < int'(t))
                  rem_in[i] = ((i == 0) ? '0 : rem_ff[(i == 0) ? 0 : i - 1])
                              ^ gf_mul(fb, gen[i*SymW +: SymW], poly);
            end
         end
         if (q_item.last && t == '0) begin
            for (int i = 0; i < MaxParity; i++) rem_in[i] = '0;
         end
         if (q_item.last) drain_in = t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         drain_ff <= '0;
         for (int i = 0; i < MaxParity; i++) rem_ff[i] <= '0;
      end else begin
         valid_ff <= valid_in;
         drain_ff <= drain_in;
         rem_ff   <= rem_in;
      end
      sym_ff <= sym_in;
      par_ff <= par_in;
      eoc_ff <= eoc_in;
   end

endmodule

// ----- hdl/rs_enc_csr.sv -----
// Configuration registers behind the APB-style port.
// Depends on rs_enc_pkg.
module rs_enc_csr
   import rs_enc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [63:0]          csr_pwdata,
   output logic [63:0]          csr_prdata,
   output logic                 csr_pready,
   output logic [SymW-1:0]      poly,
   output logic [CntW-1:0]      parity_count,
   output logic [MaxParity*SymW-1:0] gen
);

   logic [SymW-1:0] poly_ff;
   logic [CntW-1:0] cnt_ff;
   logic [63:0]     genl_ff, genh_ff;
   logic            wr;
   logic [1:0]      idx;
   logic            hit;

   assign csr_pready = 1'b1;
   assign idx = csr_paddr[4:3];
   assign hit = (csr_paddr[2:0] == 3'd0);
   assign wr  = csr_psel && csr_penable && csr_pwrite && hit;
   assign poly = poly_ff;
   assign parity_count = cnt_ff;
   assign gen = {genh_ff, genl_ff};

   always_comb begin
      csr_prdata = '0;
      if (hit) begin
         unique case (idx)
            RegFieldPoly: csr_prdata = 64'(poly_ff);
            RegParityCnt: csr_prdata = 64'(cnt_ff);
            RegGenLow:    csr_prdata = genl_ff;
            RegGenHigh:   csr_prdata = genh_ff;
            default:      csr_prdata = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= 8'd29;
         cnt_ff  <= CntW'(MaxParity);
         genl_ff <= '0;
         genh_ff <= '0;
      end else if (wr) begin
         unique case (idx)
            RegFieldPoly: poly_ff <= csr_pwdata[SymW-1:0];
            RegParityCnt: cnt_ff  <= csr_pwdata[CntW-1:0];
            RegGenLow:    genl_ff <= csr_pwdata;
            RegGenHigh:   genh_ff <= csr_pwdata;
            default:      ;
         endcase
      end
   end

endmodule

// ----- hdl/rs_enc_checker.sv -----
// Port-level checker for the encoder top level, attached by bind.
// Depends on rs_enc_pkg.
module rs_enc_port_checker
   import rs_enc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input logic [SymW-1:0] rsp_out_symbol,
   input logic            rsp_is_parity,
   input logic            rsp_end_of_codeword,
   input logic            req_stall
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_symbol))
      else $error("stalled transaction changed");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output valid after reset");

   a_reset_ready: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("input stalled after reset");

   a_eoc_after_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_is_parity && !rsp_end_of_codeword
      |=> rsp_valid && rsp_is_parity)
      else $error("parity run broken");

endmodule

bind reed_solomon_systematic_encoder_top rs_enc_port_checker u_rs_enc_checker (.*);

// ----- bench/rs_enc_checker.sv -----
`timescale 1ns / 1ps
// Checker for the Reed-Solomon encoder: watches the req_, rsp_ and csr_ ports,
// predicts each codeword byte and compares it. Depends on rs_enc_pkg.
module rs_enc_checker
   import rs_enc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  logic [SymW-1:0] req_msg_symbol,
   input  logic            req_last_symbol,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  logic [SymW-1:0] rsp_out_symbol,
   input  logic            rsp_is_parity,
   input  logic            rsp_end_of_codeword,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic            csr_pready,
   input  logic [4:0]      csr_paddr,
   input  logic [63:0]     csr_pwdata,
   output int              fail_count,
   output int              pending,
   output int              bytes_checked
);

   typedef struct {
      logic [SymW-1:0] symbol;
      logic            parity;
      logic            eoc;
   } codeword_byte_type;

   codeword_byte_type codeword_q[$];
   logic [SymW-1:0] field_poly;
   logic [CntW-1:0] parity_cnt;
   logic [63:0]     gen_low;
   logic [63:0]     gen_high;
   logic [SymW-1:0] remainder[MaxParity];

   function automatic logic [SymW-1:0] gf_times(input logic [SymW-1:0] a,
                                                input logic [SymW-1:0] b);
      logic [SymW-1:0] acc;
      logic [SymW:0]   x;
      acc = '0;
      x = {1'b0, a};
      for (int i = 0; i < SymW; i++) begin
         if (b[i]) acc ^= x[SymW-1:0];
         x = x << 1;
         if (x[SymW]) x = {1'b0, x[SymW-1:0] ^ field_poly};
      end
      return acc;
   endfunction

   function automatic logic [SymW-1:0] gen_byte(input int i);
      return (i < 8) ? gen_low[8*i +: 8] : gen_high[8*(i-8) +: 8];
   endfunction

   task automatic encode_symbol(input logic [SymW-1:0] d, input logic last);
      int t;
      logic [SymW-1:0] fb;
      codeword_byte_type entry;
      t = (parity_cnt > MaxParity) ? MaxParity : parity_cnt;
      if (t > 0) begin
         fb = d ^ remainder[t-1];
         for (int i = t - 1; i > 0; i--)
            remainder[i] = remainder[i-1] ^ gf_times(fb, gen_byte(i));
         remainder[0] = gf_times(fb, gen_byte(0));
      end
      entry = '{d, 1'b0, last && t == 0};
      codeword_q.insert(codeword_q.size(), entry);
      if (last) begin
         for (int i = t; i > 0; i--) begin
            entry = '{remainder[i-1], 1'b1, i == 1};
            codeword_q.insert(codeword_q.size(), entry);
         end
         foreach (remainder[i]) remainder[i] = '0;
      end
   endtask

   always @(posedge clock) begin
      codeword_byte_type e;
      if (reset) begin
         field_poly = 8'd29;
         parity_cnt = 5'd16;
         gen_low = '0;
         gen_high = '0;
         foreach (remainder[i]) remainder[i] = '0;
         codeword_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            unique case (csr_paddr[4:3])
               RegFieldPoly: field_poly = csr_pwdata[7:0];
               RegParityCnt: parity_cnt = csr_pwdata[4:0];
               RegGenLow:    gen_low = csr_pwdata;
               RegGenHigh:   gen_high = csr_pwdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) encode_symbol(req_msg_symbol, req_last_symbol);
         if (rsp_valid && !rsp_stall) begin
            if (codeword_q.size() == 0) begin
               $error("unexpected transaction: symbol %h", rsp_out_symbol);
               fail_count++;
            end else begin
               e = codeword_q.pop_front();
               bytes_checked++;
               if (rsp_out_symbol !== e.symbol) begin
                  $error("out_symbol: expected %h, got %h", e.symbol, rsp_out_symbol);
                  fail_count++;
               end
               if (rsp_is_parity !== e.parity) begin
                  $error("is_parity: expected %b, got %b", e.parity, rsp_is_parity);
                  fail_count++;
               end
               if (rsp_end_of_codeword !== e.eoc) begin
                  $error("end_of_codeword: expected %b, got %b", e.eoc,
                         rsp_end_of_codeword);
                  fail_count++;
               end
            end
         end
      end
      pending = codeword_q.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      bytes_checked = 0;
   end

endmodule

// ----- bench/tb_reed_solomon_systematic_encoder_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the Reed-Solomon encoder: clock, reset, register writes,
// message stimulus and verdict. Depends on rs_enc_pkg and rs_enc_checker.
module tb_reed_solomon_systematic_encoder_top;
   import rs_enc_pkg::*;

   localparam int StallLimit = 3000;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   logic [SymW-1:0] req_msg_symbol;
   logic            req_last_symbol;
   logic            rsp_valid;
   logic            rsp_stall;
   logic [SymW-1:0] rsp_out_symbol;
   logic            rsp_is_parity;
   logic            rsp_end_of_codeword;
   logic            csr_psel;
   logic            csr_penable;
   logic            csr_pwrite;
   logic [4:0]      csr_paddr;
   logic [63:0]     csr_pwdata;
   logic [63:0]     csr_prdata;
   logic            csr_pready;

   int fail_count;
   int pending;
   int bytes_checked;
   int items_sent = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit hold_request = 0;
   bit steady = 0;

   always #5 clock = ~clock;

   reed_solomon_systematic_encoder_top i_dut (.*);

   rs_enc_checker i_checker (.*);

   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = 120;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 15);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= StallLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_symbol(input logic [SymW-1:0] sym, input logic last);
      req_valid <= 1'b1;
      req_msg_symbol <= sym;
      req_last_symbol <= last;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (!steady && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic load_settings(input logic [7:0] poly, input logic [4:0] t,
                                input logic [63:0] lo, input logic [63:0] hi);
      csr_write(RegFieldPoly, {56'd0, poly});
      csr_write(RegParityCnt, {59'd0, t});
      csr_write(RegGenLow, lo);
      csr_write(RegGenHigh, hi);
   endtask

   task automatic random_blocks(input int count);
      int left;
      int blen;
      left = count;
      while (left > 0) begin
         blen = ($urandom_range(9) == 0) ? $urandom_range(30, 13) : $urandom_range(12, 1);
         if (blen > left) blen = left;
         for (int k = 0; k < blen; k++)
            send_symbol(8'($urandom_range(255)), k == blen - 1);
         left -= blen;
      end
   endtask

   initial begin
      logic [4:0] t_list[6];
      logic [7:0] poly_list[6];
      t_list = '{5'd4, 5'd0, 5'd16, 5'd31, 5'd1, 5'd0};
      poly_list = '{8'h1d, 8'h00, 8'hff, 8'h2b, 8'h1d, 8'h00};
      t_list[5] = 5'($urandom_range(15, 2));
      poly_list[5] = 8'($urandom_range(255));
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_msg_symbol <= '0;
      req_last_symbol <= 1'b0;
      rsp_stall <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_symbol(8'h00, 1'b0);
      send_symbol(8'hff, 1'b1);
      drain_and_settle();
      load_settings(8'h1d, 5'd4, 64'h0000_0000_7840_f00f, '1);
      send_symbol(8'hff, 1'b0);
      send_symbol(8'h01, 1'b0);
      send_symbol(8'h80, 1'b1);
      send_symbol(8'h5a, 1'b1);
      drain_and_settle();
      load_settings(8'hff, 5'd0, '1, '1);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'hff, 1'b1);
      drain_and_settle();
      load_settings(8'h00, 5'd31, '1, '1);
      send_symbol(8'haa, 1'b0);
      send_symbol(8'h55, 1'b1);
      drain_and_settle();
      load_settings(8'h1d, 5'd1, 64'h0000_0000_0000_0003, '0);
      send_symbol(8'hff, 1'b1);
      send_symbol(8'h00, 1'b1);
      drain_and_settle();

      for (int p = 0; p < 6; p++) begin
         load_settings(poly_list[p], t_list[p],
                       {$urandom(), $urandom()}, {$urandom(), $urandom()});
         steady = (p == 2);
         if (p == 3) begin
            hold_request = 1;
            random_blocks(40);
         end
         random_blocks(55);
         steady = 0;
         drain_and_settle();
      end

      $display("Sent %0d message bytes over settings with 0 to 31 parity requested;",
               items_sent);
      $display("checked %0d codeword bytes.", bytes_checked);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- reed_solomon_systematic_encoder_top.f -----
hdl/rs_enc_pkg.sv
hdl/rs_enc_front.sv
hdl/rs_enc_back.sv
hdl/rs_enc_csr.sv
hdl/reed_solomon_systematic_encoder_top.sv
hdl/rs_enc_checker.sv
bench/rs_enc_checker.sv
bench/tb_reed_solomon_systematic_encoder_top.sv
